// ===== rtl/tmp_pkg.sv =====
// Shared types, constants and saturation, rescaling and rounding helpers for the triangle metric block.
`default_nettype none
package tmp_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int OUT_FRAC      = 24;
  localparam int IN_W          = 32;
  localparam int EDGE_W        = IN_W + 1;
  localparam int VAL_W         = 48;
  localparam int GACC_W        = 2 * EDGE_W + 2;
  localparam int PROD_W        = 2 * VAL_W;
  localparam int NUM_W         = PROD_W + 1;
  localparam int NUM_ROWS      = 12;
  localparam int A_ROWS        = 9;

  localparam int EQ_SH  = OUT_FRAC - FRACTION_BITS;
  localparam int G_SH   = 2 * FRACTION_BITS - OUT_FRAC;
  localparam int G_SHR  = (G_SH > 0) ? G_SH : 1;
  localparam int G_SHL  = (G_SH < 0) ? -G_SH : 0;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_EDGE = 2'd0,
    KIND_GRAM = 2'd1,
    KIND_PROD = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRAM,
    ST_GSAT,
    ST_DET,
    ST_DZ,
    ST_NUM,
    ST_DIV,
    ST_PROD,
    ST_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_PREP,
    DV_CHK,
    DV_RUN,
    DV_DONE
  } div_state_t;

  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
    logic signed [IN_W-1:0] bx;
    logic signed [IN_W-1:0] by;
    logic signed [IN_W-1:0] bz;
    logic signed [IN_W-1:0] cx;
    logic signed [IN_W-1:0] cy;
    logic signed [IN_W-1:0] cz;
  } tri_t;

  typedef struct packed {
    logic [2:0][EDGE_W-1:0] e0;
    logic [2:0][EDGE_W-1:0] e1;
  } edge_set_t;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic                    sat;
    logic signed [VAL_W-1:0] q;
  } div_rsp_t;

  function automatic logic sat_over(input logic signed [PROD_W-1:0] x);
    sat_over = (x[PROD_W-1:VAL_W-1] != '0) && (x[PROD_W-1:VAL_W-1] != '1);
  endfunction

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [PROD_W-1:0] x);
    if (sat_over(x)) begin
      sat48 = x[PROD_W-1] ? VAL_MIN : VAL_MAX;
    end else begin
      sat48 = x[VAL_W-1:0];
    end
  endfunction

  // Gram entries: 2F fraction bits down to 24, round half up.
  function automatic logic signed [PROD_W-1:0] rescale_g(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(1) <<< (G_SHR - 1);
    if (G_SH > 0) begin
      rescale_g = (x + half) >>> G_SHR;
    end else begin
      rescale_g = x <<< G_SHL;
    end
  endfunction

  function automatic logic signed [PROD_W-1:0] round_out(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(1) <<< (OUT_FRAC - 1);
    round_out = (x + half) >>> OUT_FRAC;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tmp_front.sv =====
// Front stage: accepts a triangle and forms its edge vectors B - A and C - A.
`default_nettype none
module tmp_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tmp_pkg::tri_t       tri_in,
  output logic                     push,
  output tmp_pkg::edge_set_t       push_data,
  input  wire logic                push_ready
);

  logic                hold_valid_r;
  tmp_pkg::edge_set_t  hold_r;
  tmp_pkg::edge_set_t  edges;
  logic                accept;

  always_comb begin
    edges.e0[0] = tmp_pkg::EDGE_W'(tri_in.bx) - tmp_pkg::EDGE_W'(tri_in.ax);
    edges.e0[1] = tmp_pkg::EDGE_W'(tri_in.by) - tmp_pkg::EDGE_W'(tri_in.ay);
    edges.e0[2] = tmp_pkg::EDGE_W'(tri_in.bz) - tmp_pkg::EDGE_W'(tri_in.az);
    edges.e1[0] = tmp_pkg::EDGE_W'(tri_in.cx) - tmp_pkg::EDGE_W'(tri_in.ax);
    edges.e1[1] = tmp_pkg::EDGE_W'(tri_in.cy) - tmp_pkg::EDGE_W'(tri_in.ay);
    edges.e1[2] = tmp_pkg::EDGE_W'(tri_in.cz) - tmp_pkg::EDGE_W'(tri_in.az);
  end

  assign in_ready  = !hold_valid_r || push_ready;
  assign accept    = in_valid && in_ready;
  assign push      = hold_valid_r;
  assign push_data = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (push_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= edges;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tmp_fifo.sv =====
// Two-entry queue of edge sets between the front and the back.
`default_nettype none
module tmp_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire tmp_pkg::edge_set_t  push_data,
  output logic                     push_ready,
  input  wire logic                pop,
  output logic                     pop_valid,
  output tmp_pkg::edge_set_t       pop_data
);

  tmp_pkg::edge_set_t mem_r [2];
  logic               wptr_r;
  logic               rptr_r;
  logic [1:0]         count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (do_pop) rptr_r <= !rptr_r;
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tmp_mul.sv =====
// Shared signed 48x48 multiplier, one 48x16 partial product per cycle.
`default_nettype none
module tmp_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tmp_pkg::mul_req_t  req,
  output tmp_pkg::mul_rsp_t       rsp
);

  logic [tmp_pkg::VAL_W-1:0]  ua_r;
  logic [tmp_pkg::VAL_W-1:0]  ub_r;
  logic                       neg_r;
  logic [tmp_pkg::PROD_W-1:0] acc_r;
  logic [1:0]                 cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic [15:0]                chunk;
  logic [63:0]                pp;

  assign chunk = ub_r[{cnt_r, 4'b0} +: 16];
  assign pp    = ua_r * chunk;

  assign rsp.done = done_r;
  assign rsp.prod = neg_r ? $signed(-acc_r) : $signed(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= 2'd2;
      end else if (run_r) begin
        if (cnt_r == 2'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ua_r  <= req.a[tmp_pkg::VAL_W-1] ? tmp_pkg::VAL_W'(-req.a) : tmp_pkg::VAL_W'(req.a);
      ub_r  <= req.b[tmp_pkg::VAL_W-1] ? tmp_pkg::VAL_W'(-req.b) : tmp_pkg::VAL_W'(req.b);
      neg_r <= req.a[tmp_pkg::VAL_W-1] ^ req.b[tmp_pkg::VAL_W-1];
      acc_r <= '0;
    end else if (run_r) begin
      // high chunk first, so the running sum shifts by a constant
      acc_r <= (acc_r << 16) + tmp_pkg::PROD_W'(pp);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tmp_div.sv =====
// Restoring divider, one quotient bit per cycle, rounding to nearest and saturating.
`default_nettype none
module tmp_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tmp_pkg::div_req_t  req,
  output tmp_pkg::div_rsp_t       rsp
);

  localparam int NW    = tmp_pkg::NUM_W;
  localparam int REM_W = NW + tmp_pkg::OUT_FRAC + 1;
  localparam int DSH_W = NW + tmp_pkg::VAL_W;
  localparam int QW    = tmp_pkg::VAL_W;

  tmp_pkg::div_state_t state_r, state_nxt;
  logic [NW-1:0]    absn_r;
  logic [NW-1:0]    absd_r;
  logic             neg_r;
  logic             ovf_r;
  logic [REM_W-1:0] rem_r;
  logic [DSH_W-1:0] dsh_r;
  logic [QW-1:0]    qm_r;
  logic [5:0]       cnt_r;
  logic             ge;

  assign ge = DSH_W'(rem_r) >= dsh_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmp_pkg::DV_IDLE: if (req.start) state_nxt = tmp_pkg::DV_PREP;
      tmp_pkg::DV_PREP: state_nxt = tmp_pkg::DV_CHK;
      tmp_pkg::DV_CHK:  state_nxt = ge ? tmp_pkg::DV_DONE : tmp_pkg::DV_RUN;
      tmp_pkg::DV_RUN:  if (cnt_r == 6'd0) state_nxt = tmp_pkg::DV_DONE;
      tmp_pkg::DV_DONE: state_nxt = tmp_pkg::DV_IDLE;
      default:          state_nxt = tmp_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmp_pkg::DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tmp_pkg::DV_IDLE: begin
        if (req.start) begin
          absn_r <= req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
          absd_r <= req.den[NW-1] ? NW'(-req.den) : NW'(req.den);
          neg_r  <= req.num[NW-1] ^ req.den[NW-1];
        end
      end
      tmp_pkg::DV_PREP: begin
        // add half the divisor for round to nearest, ties away from zero
        rem_r <= REM_W'({absn_r, {tmp_pkg::OUT_FRAC{1'b0}}}) + REM_W'(absd_r >> 1);
        dsh_r <= {absd_r, {QW{1'b0}}};
      end
      tmp_pkg::DV_CHK: begin
        ovf_r <= ge;
        dsh_r <= dsh_r >> 1;
        cnt_r <= 6'(QW - 1);
        qm_r  <= '0;
      end
      tmp_pkg::DV_RUN: begin
        if (ge) begin
          rem_r <= rem_r - REM_W'(dsh_r);
          qm_r  <= {qm_r[QW-2:0], 1'b1};
        end else begin
          qm_r  <= {qm_r[QW-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 6'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == tmp_pkg::DV_DONE);
    if (ovf_r) begin
      rsp.sat = 1'b1;
      rsp.q   = neg_r ? tmp_pkg::VAL_MIN : tmp_pkg::VAL_MAX;
    end else if (!neg_r) begin
      rsp.sat = qm_r[QW-1];
      rsp.q   = qm_r[QW-1] ? tmp_pkg::VAL_MAX : $signed(qm_r);
    end else begin
      rsp.sat = qm_r > {1'b1, {(QW-1){1'b0}}};
      rsp.q   = rsp.sat ? tmp_pkg::VAL_MIN : $signed(QW'(-qm_r));
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tmp_back.sv =====
// Back stage: sequences Gram, determinant, inverse and product terms, then emits rows.
`default_nettype none
module tmp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire tmp_pkg::edge_set_t  q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_kind,
  output logic [3:0]               out_row,
  output logic signed [47:0]       out_value_0,
  output logic signed [47:0]       out_value_1,
  output logic signed [47:0]       out_value_2,
  output logic signed [47:0]       out_value_3,
  output logic                     out_last,
  output logic                     out_degenerate
);

  localparam int VW = tmp_pkg::VAL_W;
  localparam int PW = tmp_pkg::PROD_W;
  localparam int NW = tmp_pkg::NUM_W;
  localparam int EW = tmp_pkg::EDGE_W;
  localparam int GW = tmp_pkg::GACC_W;

  tmp_pkg::back_state_t state_r, state_nxt;
  tmp_pkg::mul_req_t    mul_req;
  tmp_pkg::mul_rsp_t    mul_rsp;
  tmp_pkg::div_req_t    div_req;
  tmp_pkg::div_rsp_t    div_rsp;

  logic [1:0] k_r, j_r, p_r, q_r;
  logic       i_r;
  logic [3:0] arow_r, orow_r;
  logic       mul_busy_r, div_busy_r;
  logic       out_valid_r;
  logic       load;

  logic signed [EW-1:0] e0_r [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [VW-1:0] eq_r [2][3];
  logic signed [GW-1:0] acc_r [3];
  logic signed [VW-1:0] g00_r, g01_r, g11_r;
  logic signed [PW-1:0] p0_r;
  logic signed [NW-1:0] det_r, num_r;
  logic signed [VW-1:0] b_r [2][3];
  logic signed [VW-1:0] abuf_r [tmp_pkg::A_ROWS][4];
  logic                 flag_r;

  logic signed [VW-1:0] eq_in [2][3];
  logic                 eq_ovf;
  logic signed [PW-1:0] gsc [3];
  logic signed [PW-1:0] a_rnd;
  logic [3:0]           brow;

  tmp_pkg::kind_t       out_kind_r;
  logic [3:0]           out_row_r;
  logic signed [VW-1:0] out_v_r [4];
  logic                 out_last_r, out_deg_r;

  tmp_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  tmp_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    eq_ovf = 1'b0;
    for (int k = 0; k < 3; k++) begin
      eq_in[0][k] = tmp_pkg::sat48(PW'($signed(q_data.e0[k])) <<< tmp_pkg::EQ_SH);
      eq_in[1][k] = tmp_pkg::sat48(PW'($signed(q_data.e1[k])) <<< tmp_pkg::EQ_SH);
      eq_ovf = eq_ovf
             | tmp_pkg::sat_over(PW'($signed(q_data.e0[k])) <<< tmp_pkg::EQ_SH)
             | tmp_pkg::sat_over(PW'($signed(q_data.e1[k])) <<< tmp_pkg::EQ_SH);
    end
    for (int k = 0; k < 3; k++) begin
      gsc[k] = tmp_pkg::rescale_g(PW'(acc_r[k]));
    end
  end

  assign a_rnd = tmp_pkg::round_out(mul_rsp.prod);
  assign load  = (state_r == tmp_pkg::ST_OUT) && (!out_valid_r || out_ready);
  assign brow  = orow_r - 4'd3;

  // next state, operand selection and unit starts
  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    div_req.start = (state_r == tmp_pkg::ST_DIV) && !div_busy_r;
    div_req.num   = num_r;
    div_req.den   = det_r;
    unique case (state_r)
      tmp_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = tmp_pkg::ST_GRAM;
        end
      end
      tmp_pkg::ST_GRAM: begin
        mul_req.start = !mul_busy_r;
        case (j_r)
          2'd0:    begin mul_req.a = VW'(e0_r[k_r]); mul_req.b = VW'(e0_r[k_r]); end
          2'd1:    begin mul_req.a = VW'(e0_r[k_r]); mul_req.b = VW'(e1_r[k_r]); end
          default: begin mul_req.a = VW'(e1_r[k_r]); mul_req.b = VW'(e1_r[k_r]); end
        endcase
        if (mul_rsp.done && k_r == 2'd2 && j_r == 2'd2) state_nxt = tmp_pkg::ST_GSAT;
      end
      tmp_pkg::ST_GSAT: state_nxt = tmp_pkg::ST_DET;
      tmp_pkg::ST_DET: begin
        mul_req.start = !mul_busy_r;
        mul_req.a     = (j_r == 2'd0) ? g00_r : g01_r;
        mul_req.b     = (j_r == 2'd0) ? g11_r : g01_r;
        if (mul_rsp.done && j_r == 2'd1) state_nxt = tmp_pkg::ST_DZ;
      end
      tmp_pkg::ST_DZ: begin
        state_nxt = (det_r == '0) ? tmp_pkg::ST_PROD : tmp_pkg::ST_NUM;
      end
      tmp_pkg::ST_NUM: begin
        mul_req.start = !mul_busy_r;
        if (j_r == 2'd0) begin
          mul_req.a = i_r ? g00_r : g11_r;
          mul_req.b = eq_r[i_r][k_r];
        end else begin
          mul_req.a = g01_r;
          mul_req.b = eq_r[!i_r][k_r];
        end
        if (mul_rsp.done && j_r == 2'd1) state_nxt = tmp_pkg::ST_DIV;
      end
      tmp_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (k_r == 2'd2 && i_r) ? tmp_pkg::ST_PROD : tmp_pkg::ST_NUM;
        end
      end
      tmp_pkg::ST_PROD: begin
        mul_req.start = !mul_busy_r;
        mul_req.a     = b_r[j_r[1]][p_r];
        mul_req.b     = b_r[j_r[0]][q_r];
        if (mul_rsp.done && j_r == 2'd3 && p_r == 2'd2 && q_r == 2'd2) begin
          state_nxt = tmp_pkg::ST_OUT;
        end
      end
      tmp_pkg::ST_OUT: begin
        if (load && orow_r == 4'(tmp_pkg::NUM_ROWS - 1)) state_nxt = tmp_pkg::ST_IDLE;
      end
      default: state_nxt = tmp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmp_pkg::ST_IDLE;
      mul_busy_r  <= 1'b0;
      div_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
      j_r         <= 2'd0;
      i_r         <= 1'b0;
      p_r         <= 2'd0;
      q_r         <= 2'd0;
      arow_r      <= 4'd0;
      orow_r      <= 4'd0;
    end else begin
      state_r <= state_nxt;
      if (mul_req.start) begin
        mul_busy_r <= 1'b1;
      end else if (mul_rsp.done) begin
        mul_busy_r <= 1'b0;
      end
      if (div_req.start) begin
        div_busy_r <= 1'b1;
      end else if (div_rsp.done) begin
        div_busy_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        tmp_pkg::ST_IDLE: begin
          k_r <= 2'd0;
          j_r <= 2'd0;
        end
        tmp_pkg::ST_GRAM: begin
          if (mul_rsp.done) begin
            if (j_r == 2'd2) begin
              j_r <= 2'd0;
              k_r <= k_r + 2'd1;
            end else begin
              j_r <= j_r + 2'd1;
            end
          end
        end
        tmp_pkg::ST_GSAT: begin
          k_r    <= 2'd0;
          j_r    <= 2'd0;
          i_r    <= 1'b0;
          p_r    <= 2'd0;
          q_r    <= 2'd0;
          arow_r <= 4'd0;
          orow_r <= 4'd0;
        end
        tmp_pkg::ST_DET, tmp_pkg::ST_NUM: begin
          if (mul_rsp.done) j_r <= (j_r == 2'd0) ? 2'd1 : 2'd0;
        end
        tmp_pkg::ST_DIV: begin
          if (div_rsp.done) begin
            if (k_r == 2'd2) begin
              k_r <= 2'd0;
              i_r <= 1'b1;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        tmp_pkg::ST_PROD: begin
          if (mul_rsp.done) begin
            j_r <= j_r + 2'd1;
            if (j_r == 2'd3) begin
              arow_r <= arow_r + 4'd1;
              if (q_r == 2'd2) begin
                q_r <= 2'd0;
                p_r <= p_r + 2'd1;
              end else begin
                q_r <= q_r + 2'd1;
              end
            end
          end
        end
        tmp_pkg::ST_OUT: begin
          if (load) orow_r <= orow_r + 4'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tmp_pkg::ST_IDLE: begin
        if (q_valid) begin
          for (int k = 0; k < 3; k++) begin
            e0_r[k]    <= $signed(q_data.e0[k]);
            e1_r[k]    <= $signed(q_data.e1[k]);
            eq_r[0][k] <= eq_in[0][k];
            eq_r[1][k] <= eq_in[1][k];
            acc_r[k]   <= '0;
          end
          flag_r <= eq_ovf;
        end
      end
      tmp_pkg::ST_GRAM: begin
        if (mul_rsp.done) acc_r[j_r] <= acc_r[j_r] + GW'(mul_rsp.prod);
      end
      tmp_pkg::ST_GSAT: begin
        g00_r  <= tmp_pkg::sat48(gsc[0]);
        g01_r  <= tmp_pkg::sat48(gsc[1]);
        g11_r  <= tmp_pkg::sat48(gsc[2]);
        flag_r <= flag_r | tmp_pkg::sat_over(gsc[0]) | tmp_pkg::sat_over(gsc[1])
                         | tmp_pkg::sat_over(gsc[2]);
      end
      tmp_pkg::ST_DET, tmp_pkg::ST_NUM: begin
        if (mul_rsp.done) begin
          if (j_r == 2'd0) begin
            p0_r <= mul_rsp.prod;
          end else if (state_r == tmp_pkg::ST_DET) begin
            det_r <= NW'(p0_r) - NW'(mul_rsp.prod);
          end else begin
            num_r <= NW'(p0_r) - NW'(mul_rsp.prod);
          end
        end
      end
      tmp_pkg::ST_DZ: begin
        // singular metric: inverse terms drop to zero
        if (det_r == '0) begin
          flag_r <= 1'b1;
          for (int k = 0; k < 3; k++) begin
            b_r[0][k] <= '0;
            b_r[1][k] <= '0;
          end
        end
      end
      tmp_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          b_r[i_r][k_r] <= div_rsp.q;
          flag_r        <= flag_r | div_rsp.sat;
        end
      end
      tmp_pkg::ST_PROD: begin
        if (mul_rsp.done) begin
          abuf_r[arow_r][j_r] <= tmp_pkg::sat48(a_rnd);
          flag_r              <= flag_r | tmp_pkg::sat_over(a_rnd);
        end
      end
      tmp_pkg::ST_OUT: begin
        if (load) begin
          out_last_r <= (orow_r == 4'(tmp_pkg::NUM_ROWS - 1));
          out_deg_r  <= flag_r;
          if (orow_r < 4'd2) begin
            out_kind_r <= tmp_pkg::KIND_EDGE;
            out_row_r  <= orow_r;
            out_v_r[0] <= eq_r[orow_r[0]][0];
            out_v_r[1] <= eq_r[orow_r[0]][1];
            out_v_r[2] <= eq_r[orow_r[0]][2];
            out_v_r[3] <= '0;
          end else if (orow_r == 4'd2) begin
            out_kind_r <= tmp_pkg::KIND_GRAM;
            out_row_r  <= 4'd0;
            out_v_r[0] <= g00_r;
            out_v_r[1] <= g01_r;
            out_v_r[2] <= g01_r;
            out_v_r[3] <= g11_r;
          end else begin
            out_kind_r <= tmp_pkg::KIND_PROD;
            out_row_r  <= brow;
            for (int c = 0; c < 4; c++) begin
              out_v_r[c] <= abuf_r[brow][c];
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_row        = out_row_r;
  assign out_value_0    = out_v_r[0];
  assign out_value_1    = out_v_r[1];
  assign out_value_2    = out_v_r[2];
  assign out_value_3    = out_v_r[3];
  assign out_last       = out_last_r;
  assign out_degenerate = out_deg_r;

endmodule
`default_nettype wire

// ===== rtl/triangle_metric_precompute.sv =====
// Triangle metric precompute: edges, Gram matrix, inverse-metric products.
// The shared multiplier forms one 48x16 partial product per cycle for each of up to 59
// products, and the divider one quotient bit per cycle for each of up to 6 quotients.
// 12 result rows per triangle; the back takes a new one only after its last row loads.
// The front and a two-entry queue take three more triangles while the back is busy.
// Reset: synchronous active-low rst_n clears all control state; no clearing pass.
`default_nettype none
module triangle_metric_precompute (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_ax,
  input  wire logic signed [31:0] in_ay,
  input  wire logic signed [31:0] in_az,
  input  wire logic signed [31:0] in_bx,
  input  wire logic signed [31:0] in_by,
  input  wire logic signed [31:0] in_bz,
  input  wire logic signed [31:0] in_cx,
  input  wire logic signed [31:0] in_cy,
  input  wire logic signed [31:0] in_cz,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic [3:0]              out_row,
  output logic signed [47:0]      out_value_0,
  output logic signed [47:0]      out_value_1,
  output logic signed [47:0]      out_value_2,
  output logic signed [47:0]      out_value_3,
  output logic                    out_last,
  output logic                    out_degenerate
);

  tmp_pkg::tri_t      tri_in;
  tmp_pkg::edge_set_t push_data;
  tmp_pkg::edge_set_t pop_data;
  logic               push, push_ready, pop, pop_valid;

  always_comb begin
    tri_in.ax = in_ax;
    tri_in.ay = in_ay;
    tri_in.az = in_az;
    tri_in.bx = in_bx;
    tri_in.by = in_by;
    tri_in.bz = in_bz;
    tri_in.cx = in_cx;
    tri_in.cy = in_cy;
    tri_in.cz = in_cz;
  end

  tmp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .tri_in     (tri_in),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  tmp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  tmp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_data         (pop_data),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_row        (out_row),
    .out_value_0    (out_value_0),
    .out_value_1    (out_value_1),
    .out_value_2    (out_value_2),
    .out_value_3    (out_value_3),
    .out_last       (out_last),
    .out_degenerate (out_degenerate)
  );

endmodule
`default_nettype wire
